>>> rtl/core/ubsd_pkg.sv
`timescale 1ns / 1ps

package ubsd_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned PendW = 2;

  localparam logic [CpW-1:0] ReplCp = 21'h00fffd;

  typedef struct packed {
    logic           vld;
    logic [CpW-1:0] code_point;
    logic           malformed;
  } ubsd_res_t;

endpackage

>>> rtl/core/ubsd_in_reg.sv
`timescale 1ns / 1ps

module ubsd_in_reg
  import ubsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       ready_dn,
  output logic       fire,
  output logic [7:0] byte_q
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;
  logic       load;

  assign fire     = vld_r & ready_dn;
  assign in_stall = vld_r & ~ready_dn;
  assign load     = in_valid & ~in_stall;
  assign vld_nxt  = load | (vld_r & ~fire);
  assign byte_q   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

endmodule

>>> rtl/core/ubsd_core.sv
`timescale 1ns / 1ps

module ubsd_core
  import ubsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] byte_q,
  output ubsd_res_t  res
);

  logic [CpW-1:0]   part_r;
  logic [CpW-1:0]   part_nxt;
  logic [PendW-1:0] pend_r;
  logic [PendW-1:0] pend_nxt;
  logic             seq_r;
  logic             seq_nxt;
  logic [PendW-1:0] pend_dec;
  logic [CpW-1:0]   cont_val;

  assign pend_dec = pend_r - 2'd1;

  always_comb begin
    cont_val = part_r;
    case (pend_dec)
      2'd0:    cont_val[5:0]   = part_r[5:0]   | byte_q[5:0];
      2'd1:    cont_val[11:6]  = part_r[11:6]  | byte_q[5:0];
      2'd2:    cont_val[17:12] = part_r[17:12] | byte_q[5:0];
      default: cont_val[20:18] = part_r[20:18] | byte_q[2:0];
    endcase
  end

  always_comb begin
    part_nxt = part_r;
    pend_nxt = pend_r;
    seq_nxt  = seq_r;
    res      = '{vld: 1'b0, code_point: '0, malformed: 1'b0};
    if (!seq_r || pend_r == '0) begin
      if (!byte_q[7]) begin
        res      = '{vld: 1'b1, code_point: {13'd0, byte_q}, malformed: 1'b0};
        part_nxt = '0;
        pend_nxt = '0;
        seq_nxt  = 1'b0;
      end else if (byte_q[7:5] == 3'b110) begin
        part_nxt = {10'd0, byte_q[4:0], 6'd0};
        pend_nxt = 2'd1;
        seq_nxt  = 1'b1;
      end else if (byte_q[7:4] == 4'b1110) begin
        part_nxt = {5'd0, byte_q[3:0], 12'd0};
        pend_nxt = 2'd2;
        seq_nxt  = 1'b1;
      end else if (byte_q[7:3] == 5'b11110) begin
        part_nxt = {byte_q[2:0], 18'd0};
        pend_nxt = 2'd3;
        seq_nxt  = 1'b1;
      end else begin
        res      = '{vld: 1'b1, code_point: ReplCp, malformed: 1'b1};
        part_nxt = '0;
        pend_nxt = '0;
        seq_nxt  = 1'b0;
      end
    end else if (byte_q[7:6] != 2'b10) begin
      res      = '{vld: 1'b1, code_point: ReplCp, malformed: 1'b1};
      part_nxt = '0;
      pend_nxt = '0;
      seq_nxt  = 1'b0;
    end else if (pend_dec == '0) begin
      res      = '{vld: 1'b1, code_point: cont_val, malformed: 1'b0};
      part_nxt = '0;
      pend_nxt = '0;
      seq_nxt  = 1'b0;
    end else begin
      part_nxt = cont_val;
      pend_nxt = pend_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      pend_r <= '0;
      seq_r  <= 1'b0;
    end else if (fire) begin
      part_r <= part_nxt;
      pend_r <= pend_nxt;
      seq_r  <= seq_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_seq_pend: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == (pend_r != '0))
    else $error("sequence flag out of step with pending count");

  a_bad_repl: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && res.malformed |-> res.code_point == ReplCp)
    else $error("malformed result without replacement value");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.vld |=> !seq_r && pend_r == '0 && part_r == '0)
    else $error("state not cleared after emitted code point");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(pend_r) && $stable(part_r))
    else $error("state changed without a transaction");
`endif

endmodule

>>> rtl/core/ubsd_out_reg.sv
`timescale 1ns / 1ps

module ubsd_out_reg
  import ubsd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  ubsd_res_t      res,
  output logic           ready_dn,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CpW-1:0] out_code_point,
  output logic           out_malformed
);

  logic           vld_r;
  logic           vld_nxt;
  logic [CpW-1:0] cp_r;
  logic           bad_r;
  logic           load;

  assign ready_dn = ~vld_r | ~out_stall;
  assign load     = fire & res.vld;
  assign vld_nxt  = load | (vld_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= res.code_point;
      bad_r <= res.malformed;
    end
  end

  assign out_valid      = vld_r;
  assign out_code_point = cp_r;
  assign out_malformed  = bad_r;

endmodule

>>> rtl/core/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid, in_stall   | in_byte[7:0]
// out     | out_valid, out_stall | out_code_point[20:0], out_malformed
//
// one byte per cycle sustained while out_stall is low
// the input register feeds the decode logic, which writes the result register
// synchronous reset clears both valid flags and the decode state
// out_stall holds the result; the input side stalls only when the result is held
// and a byte is already waiting in the input register

module utf8_byte_stream_decoder
  import ubsd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [CpW-1:0] out_code_point,
  output logic           out_malformed
);

  logic      ready_dn;
  logic      fire;
  logic [7:0] byte_q;
  ubsd_res_t res;

  ubsd_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .ready_dn (ready_dn),
    .fire     (fire),
    .byte_q   (byte_q)
  );

  ubsd_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .byte_q (byte_q),
    .res    (res)
  );

  ubsd_out_reg u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .res            (res),
    .ready_dn       (ready_dn),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_malformed  (out_malformed)
  );

endmodule
